// ===== rtl/refpa_pkg.sv =====
package refpa_pkg;

  localparam int NUM_PAGES  = 32768;
  localparam int COUNT_BITS = 16;

  localparam int ADDR_W     = $clog2(NUM_PAGES);
  localparam int LINK_W     = ADDR_W + 1;
  localparam int PAGE_W     = 15;
  localparam int CNT_OUT_W  = 16;
  localparam int CFG_W      = 16;
  localparam int CMD_W      = 2;
  localparam int ST_W       = 2;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [CFG_W-1:0]      CFG_RESET = CFG_W'(256);
  localparam logic [LINK_W-1:0]     NONE_LINK = LINK_W'(NUM_PAGES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [REG_IDX_W-1:0]  REG_FIRST_FREE = REG_IDX_W'(0);

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_SHARE = 2'd3
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_INVALID   = 2'd2,
    ST_SATURATED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_SWEEP_RST,
    FSM_IDLE,
    FSM_EXEC,
    FSM_SWEEP_INIT,
    FSM_INIT_RESP
  } fsm_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic sweep;
    logic init_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } dp_sts_t;

  // Clamp the reserved boundary to the page count.
  function automatic logic [LINK_W-1:0] clamp_bound(logic [CFG_W-1:0] v);
    logic [LINK_W-1:0] r;
    if (32'(v) >= NUM_PAGES) begin
      r = NONE_LINK;
    end else begin
      r = LINK_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== rtl/refpa_ctrl.sv =====
module refpa_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [refpa_pkg::CMD_W-1:0]    command_i,
  output logic                           in_ready_o,
  input  refpa_pkg::dp_sts_t             sts_i,
  output refpa_pkg::ctrl_cmd_t           cmd_o
);

  refpa_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= refpa_pkg::FSM_SWEEP_RST;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      refpa_pkg::FSM_SWEEP_RST: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = refpa_pkg::FSM_IDLE;
        end
      end
      refpa_pkg::FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (command_i == refpa_pkg::CMD_INIT) begin
            state_d = refpa_pkg::FSM_SWEEP_INIT;
          end else begin
            state_d = refpa_pkg::FSM_EXEC;
          end
        end
      end
      refpa_pkg::FSM_EXEC: begin
        // hold the update until the output slot frees up
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = refpa_pkg::FSM_IDLE;
        end
      end
      refpa_pkg::FSM_SWEEP_INIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = refpa_pkg::FSM_INIT_RESP;
        end
      end
      refpa_pkg::FSM_INIT_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.init_done = 1'b1;
          state_d         = refpa_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = refpa_pkg::FSM_IDLE;
      end
    endcase
  end

  a_exec_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.exec || cmd_o.init_done) |-> sts_i.out_free)
    else $error("result loaded while output slot busy");

  a_sweep_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sweep |-> !in_ready_o)
    else $error("request taken during clearing pass");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && command_i != refpa_pkg::CMD_INIT) |=>
      state_q == refpa_pkg::FSM_EXEC)
    else $error("accepted request did not reach execute");

  a_exec_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> in_ready_o)
    else $error("no return to idle after execute");

endmodule

// ===== rtl/refpa_dp.sv =====
module refpa_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  refpa_pkg::ctrl_cmd_t               cmd_i,
  output refpa_pkg::dp_sts_t                 sts_o,
  input  logic [refpa_pkg::CFG_W-1:0]        first_free_page_i,
  input  logic [refpa_pkg::CMD_W-1:0]        command_i,
  input  logic [refpa_pkg::PAGE_W-1:0]       page_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [refpa_pkg::PAGE_W-1:0]       result_page_o,
  output logic [refpa_pkg::CNT_OUT_W-1:0]    ref_count_o,
  output logic [refpa_pkg::ST_W-1:0]         status_o
);

  localparam int ADDR_W = refpa_pkg::ADDR_W;
  localparam int LINK_W = refpa_pkg::LINK_W;
  localparam int CNT_W  = refpa_pkg::COUNT_BITS;

  logic [CNT_W-1:0]  cnt_mem  [refpa_pkg::NUM_PAGES];
  logic [LINK_W-1:0] link_mem [refpa_pkg::NUM_PAGES];

  refpa_pkg::cmd_e                 item_cmd_q;
  logic [refpa_pkg::PAGE_W-1:0]    item_page_q;
  logic [LINK_W-1:0]               bound_q;
  logic [ADDR_W-1:0]               sweep_q;
  logic [LINK_W-1:0]               head_q, head_d;
  logic [CNT_W-1:0]                cnt_rd_q;
  logic [LINK_W-1:0]               link_rd_q;

  logic                            out_valid_q;
  logic [refpa_pkg::PAGE_W-1:0]    res_page_q, res_page_d;
  logic [refpa_pkg::CNT_OUT_W-1:0] res_cnt_q, res_cnt_d;
  logic [refpa_pkg::ST_W-1:0]      res_st_q, res_st_d;

  logic [ADDR_W-1:0]               rd_addr;
  logic [ADDR_W-1:0]               wr_addr;
  logic                            cnt_we, link_we;
  logic [CNT_W-1:0]                cnt_wd;
  logic [LINK_W-1:0]               link_wd;

  logic                            sweep_last;
  logic                            sweep_rsv;
  logic                            head_empty;
  logic                            page_bad;
  logic [CNT_W-1:0]                cnt_dec, cnt_inc;

  assign sweep_last = sweep_q == ADDR_W'(refpa_pkg::NUM_PAGES - 1);
  assign sweep_rsv  = LINK_W'(sweep_q) < bound_q;
  assign head_empty = head_q >= refpa_pkg::NONE_LINK;
  assign page_bad   = (32'(item_page_q) >= refpa_pkg::NUM_PAGES) || (cnt_rd_q == '0);
  assign cnt_dec    = cnt_rd_q - CNT_W'(1);
  assign cnt_inc    = cnt_rd_q + CNT_W'(1);

  assign sts_o.sweep_last = sweep_last;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign rd_addr = (command_i == refpa_pkg::CMD_ALLOC) ? head_q[ADDR_W-1:0]
                                                      : ADDR_W'(page_i);

  // item capture and boundary latch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_cmd_q <= refpa_pkg::CMD_INIT;
      bound_q    <= refpa_pkg::clamp_bound(refpa_pkg::CFG_RESET);
      sweep_q    <= '0;
      head_q     <= refpa_pkg::clamp_bound(refpa_pkg::CFG_RESET);
    end else begin
      head_q <= head_d;
      if (cmd_i.accept) begin
        item_cmd_q <= refpa_pkg::cmd_e'(command_i);
        if (command_i == refpa_pkg::CMD_INIT) begin
          bound_q <= refpa_pkg::clamp_bound(first_free_page_i);
          sweep_q <= '0;
        end
      end else if (cmd_i.sweep) begin
        sweep_q <= sweep_last ? '0 : sweep_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_page_q <= page_i;
    end
  end

  // memory write and read ports
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wd;
    end
    if (cmd_i.accept) begin
      cnt_rd_q <= cnt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[wr_addr] <= link_wd;
    end
    if (cmd_i.accept) begin
      link_rd_q <= link_mem[rd_addr];
    end
  end

  always_comb begin
    wr_addr    = ADDR_W'(item_page_q);
    cnt_we     = 1'b0;
    link_we    = 1'b0;
    cnt_wd     = cnt_dec;
    link_wd    = head_q;
    head_d     = head_q;
    res_page_d = item_page_q;
    res_cnt_d  = '0;
    res_st_d   = refpa_pkg::ST_INVALID;

    if (cmd_i.sweep) begin
      wr_addr = sweep_q;
      cnt_we  = 1'b1;
      link_we = 1'b1;
      cnt_wd  = sweep_rsv ? CNT_W'(1) : '0;
      link_wd = sweep_rsv ? refpa_pkg::NONE_LINK : LINK_W'(sweep_q) + LINK_W'(1);
      if (sweep_last) begin
        head_d = bound_q;
      end
    end

    case (item_cmd_q)
      refpa_pkg::CMD_ALLOC: begin
        if (head_empty) begin
          res_page_d = '0;
          res_st_d   = refpa_pkg::ST_EMPTY;
        end else begin
          res_page_d = refpa_pkg::PAGE_W'(head_q);
          res_cnt_d  = refpa_pkg::CNT_OUT_W'(CNT_W'(1));
          res_st_d   = refpa_pkg::ST_OK;
          if (cmd_i.exec) begin
            wr_addr = head_q[ADDR_W-1:0];
            cnt_we  = 1'b1;
            link_we = 1'b1;
            cnt_wd  = CNT_W'(1);
            link_wd = refpa_pkg::NONE_LINK;
            head_d  = link_rd_q;
          end
        end
      end
      refpa_pkg::CMD_FREE: begin
        if (!page_bad) begin
          res_cnt_d = refpa_pkg::CNT_OUT_W'(cnt_dec);
          res_st_d  = refpa_pkg::ST_OK;
          if (cmd_i.exec) begin
            cnt_we = 1'b1;
            cnt_wd = cnt_dec;
            // last reference gone: push onto the free list
            if (cnt_dec == '0) begin
              link_we = 1'b1;
              link_wd = head_q;
              head_d  = LINK_W'(item_page_q);
            end
          end
        end
      end
      refpa_pkg::CMD_SHARE: begin
        if (!page_bad) begin
          if (cnt_rd_q == refpa_pkg::COUNT_MAX) begin
            res_cnt_d = refpa_pkg::CNT_OUT_W'(refpa_pkg::COUNT_MAX);
            res_st_d  = refpa_pkg::ST_SATURATED;
          end else begin
            res_cnt_d = refpa_pkg::CNT_OUT_W'(cnt_inc);
            res_st_d  = refpa_pkg::ST_OK;
            if (cmd_i.exec) begin
              cnt_we = 1'b1;
              cnt_wd = cnt_inc;
            end
          end
        end
      end
      default: begin
        res_page_d = '0;
        res_cnt_d  = '0;
        res_st_d   = refpa_pkg::ST_OK;
      end
    endcase
  end

  // output slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec || cmd_i.init_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec || cmd_i.init_done) begin
      res_page_q <= res_page_d;
      res_cnt_q  <= res_cnt_d;
      res_st_q   <= res_st_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_page_o = res_page_q;
  assign ref_count_o   = res_cnt_q;
  assign status_o      = res_st_q;

endmodule

// ===== rtl/refcounted_page_allocator.sv =====
// Free, share and allocate: memories are read when the request is accepted; the
// result is registered once the output slot is free, and no new request is taken
// until the read-modify-write of the count and link memories has completed.
// Init: the entries are rewritten, one count/link entry per cycle, then the result
// is registered once the output slot is free and the block returns to idle.
// Reset: a pass over all 32768 entries rebuilds the lists with a boundary of 256;
// in_ready_o stays low until it ends, register writes are taken.
module refcounted_page_allocator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [refpa_pkg::CMD_W-1:0]           command_i,
  input  logic [refpa_pkg::PAGE_W-1:0]          page_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [refpa_pkg::PAGE_W-1:0]          result_page_o,
  output logic [refpa_pkg::CNT_OUT_W-1:0]       ref_count_o,
  output logic [refpa_pkg::ST_W-1:0]            status_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [refpa_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [refpa_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [refpa_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                  pready
);

  logic [refpa_pkg::CFG_W-1:0]     first_free_q;
  logic [refpa_pkg::REG_IDX_W-1:0] reg_idx;
  refpa_pkg::ctrl_cmd_t            cmd;
  refpa_pkg::dp_sts_t              sts;

  assign reg_idx = paddr[refpa_pkg::APB_ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_free_q <= refpa_pkg::CFG_RESET;
    end else if (psel && penable && pwrite && reg_idx == refpa_pkg::REG_FIRST_FREE) begin
      first_free_q <= pwdata[refpa_pkg::CFG_W-1:0];
    end
  end

  assign prdata = (reg_idx == refpa_pkg::REG_FIRST_FREE) ?
                  refpa_pkg::APB_DATA_W'(first_free_q) : '0;

  refpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  refpa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .first_free_page_i (first_free_q),
    .command_i         (command_i),
    .page_i            (page_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .result_page_o     (result_page_o),
    .ref_count_o       (ref_count_o),
    .status_o          (status_o)
  );

endmodule
